// ===== src/tasf_pkg.sv =====
// ----------------------------------------------------------------------------
// tasf_pkg
// Shared types, constants and helpers of the two-axis stepper follower.
// ----------------------------------------------------------------------------
package tasf_pkg;

   localparam int POSITION_BITS = 24;
   localparam int FIELD_BITS    = 24;
   localparam int CFG_BITS      = 8;
   localparam int THR_BITS      = 2 * CFG_BITS;
   // error plus threshold must fit without overflow
   localparam int ERR_BITS      = ((POSITION_BITS + 1 > THR_BITS + 1) ?
                                   (POSITION_BITS + 1) : (THR_BITS + 1)) + 1;

   typedef logic signed [POSITION_BITS-1:0] pos_type;
   typedef logic signed [FIELD_BITS-1:0]    field_type;
   typedef logic signed [ERR_BITS-1:0]      err_type;
   typedef logic        [CFG_BITS-1:0]      cfg_type;
   typedef logic        [THR_BITS-1:0]      thr_type;
   typedef logic        [1:0]               phase_type;
   typedef logic        [3:0]               coils_type;

   // item opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // register indexes
   localparam logic CSR_STEP_SIZE = 1'b0;
   localparam logic CSR_TOLERANCE = 1'b1;

   localparam cfg_type STEP_SIZE_RESET = 8'd12;
   localparam cfg_type TOLERANCE_RESET = 8'd4;

   // per-axis control from the top level
   typedef struct packed {
      logic update;   // item moves to the result stage this cycle
      logic load;     // item is a load, not a tick
   } axis_ctl_type;

   // full-step coil sequence
   function automatic coils_type coil_pattern(input phase_type idx);
      coils_type pat;
      case (idx)
         2'd0:    pat = 4'b1010;
         2'd1:    pat = 4'b1001;
         2'd2:    pat = 4'b0101;
         default: pat = 4'b0110;
      endcase
      return pat;
   endfunction

endpackage

// ===== src/tasf_csr.sv =====
// ----------------------------------------------------------------------------
// tasf_csr
// Configuration registers and the registered deadband threshold.
// ----------------------------------------------------------------------------
module tasf_csr
   import tasf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_write,
   input  logic    csr_index,
   input  cfg_type csr_wdata,
   output cfg_type step_size,
   output thr_type threshold
);

   cfg_type step_size_ff, step_size_in;
   cfg_type tolerance_ff, tolerance_in;
   thr_type threshold_ff, threshold_in;

   always_comb begin
      step_size_in = step_size_ff;
      tolerance_in = tolerance_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_STEP_SIZE: step_size_in = csr_wdata;
            CSR_TOLERANCE: tolerance_in = csr_wdata;
            default: ;
         endcase
      end
      threshold_in = thr_type'(step_size_ff) * thr_type'(tolerance_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= STEP_SIZE_RESET;
         tolerance_ff <= TOLERANCE_RESET;
         threshold_ff <= thr_type'(STEP_SIZE_RESET) * thr_type'(TOLERANCE_RESET);
      end else begin
         step_size_ff <= step_size_in;
         tolerance_ff <= tolerance_in;
         threshold_ff <= threshold_in;
      end
   end

   assign step_size = step_size_ff;
   assign threshold = threshold_ff;

endmodule

// ===== src/tasf_axis.sv =====
// ----------------------------------------------------------------------------
// tasf_axis
// One axis: position and phase state, deadband compare and full step.
// ----------------------------------------------------------------------------
module tasf_axis
   import tasf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  axis_ctl_type ctl,
   input  field_type    goal,
   input  field_type    load_value,
   input  cfg_type      step_size,
   input  thr_type      threshold,
   output coils_type    coils_next,
   output logic         arrived_next,
   output field_type    position_next
);

   pos_type   position_ff, position_in;
   phase_type phase_ff, phase_in;

   pos_type goal_pos;
   err_type err;
   err_type thr_ext;
   err_type err_plus_thr;
   err_type err_minus_thr;
   logic    step_fwd;
   logic    step_back;

   always_comb begin
      goal_pos      = pos_type'(goal);
      err           = err_type'(position_ff) - err_type'(goal_pos);
      thr_ext       = err_type'(threshold);
      err_plus_thr  = err + thr_ext;
      err_minus_thr = err - thr_ext;
      step_fwd      = err_plus_thr[ERR_BITS-1];      // err < -thr
      step_back     = !err_minus_thr[ERR_BITS-1];    // err >= thr

      position_in  = position_ff;
      phase_in     = phase_ff;
      arrived_next = 1'b0;
      if (ctl.load) begin
         position_in = pos_type'(load_value);
      end else if (step_fwd) begin
         position_in = position_ff + pos_type'(step_size);
         phase_in    = phase_ff + 2'd1;
      end else if (step_back) begin
         position_in = position_ff - pos_type'(step_size);
         phase_in    = phase_ff - 2'd1;
      end else begin
         arrived_next = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         phase_ff    <= '0;
      end else if (ctl.update) begin
         position_ff <= position_in;
         phase_ff    <= phase_in;
      end
   end

   assign coils_next    = coil_pattern(phase_in);
   assign position_next = field_type'(position_in);

endmodule

// ===== src/two_axis_stepper_follower.sv =====
// ----------------------------------------------------------------------------
// two_axis_stepper_follower
// Two-axis full-step position follower with deadband and position load.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: op (tick or load), goals and load values for
//   both axes. It is taken when req_valid is high and req_stall is low.
//   rsp_* returns one result per item: coil patterns, arrived flags and
//   positions after the item. The result is taken when rsp_valid is high
//   and rsp_stall is low.
//   csr_* writes step_size (index 0) and tolerance_steps (index 1); write
//   only while no item is in flight.
// Timing:
//   An accepted item passes the input register, then the result register,
//   before its result handshake; the compare-and-step logic of each axis sits
//   between those two registers. One item per cycle sustained while rsp_stall
//   stays low. The threshold is a registered 8x8 product of the
//   configuration registers.
// Reset:
//   Synchronous, active high. Positions and phases clear to zero (coils
//   1010), step_size to 12, tolerance_steps to 4, both stages empty.
// Stall:
//   A stalled result holds; the input register still takes one more item,
//   then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module two_axis_stepper_follower
   import tasf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   // input items
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_op,
   input  field_type req_goal_x,
   input  field_type req_goal_y,
   input  field_type req_load_x,
   input  field_type req_load_y,
   // result items
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output coils_type rsp_coils_x,
   output coils_type rsp_coils_y,
   output logic      rsp_arrived_x,
   output logic      rsp_arrived_y,
   output field_type rsp_position_x,
   output field_type rsp_position_y,
   // configuration
   input  logic      csr_write,
   input  logic      csr_index,
   input  cfg_type   csr_wdata
);

   // input stage
   logic      in_valid_ff, in_valid_in;
   logic      op_ff;
   field_type goal_x_ff, goal_y_ff, load_x_ff, load_y_ff;

   // result stage
   logic      out_valid_ff, out_valid_in;
   coils_type coils_x_ff, coils_y_ff;
   logic      arrived_x_ff, arrived_y_ff;
   field_type position_x_ff, position_y_ff;

   logic         req_take;
   logic         advance;
   axis_ctl_type axis_ctl;

   cfg_type   step_size;
   thr_type   threshold;
   coils_type coils_x_next, coils_y_next;
   logic      arrived_x_next, arrived_y_next;
   field_type position_x_next, position_y_next;

   // item moves forward when the result register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign axis_ctl.update = advance;
   assign axis_ctl.load   = (op_ff == OP_LOAD);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff     <= req_op;
         goal_x_ff <= req_goal_x;
         goal_y_ff <= req_goal_y;
         load_x_ff <= req_load_x;
         load_y_ff <= req_load_y;
      end
      if (advance) begin
         coils_x_ff    <= coils_x_next;
         coils_y_ff    <= coils_y_next;
         arrived_x_ff  <= arrived_x_next;
         arrived_y_ff  <= arrived_y_next;
         position_x_ff <= position_x_next;
         position_y_ff <= position_y_next;
      end
   end

   tasf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_size (step_size),
      .threshold (threshold)
   );

   tasf_axis u_axis_x (
      .clock         (clock),
      .reset         (reset),
      .ctl           (axis_ctl),
      .goal          (goal_x_ff),
      .load_value    (load_x_ff),
      .step_size     (step_size),
      .threshold     (threshold),
      .coils_next    (coils_x_next),
      .arrived_next  (arrived_x_next),
      .position_next (position_x_next)
   );

   tasf_axis u_axis_y (
      .clock         (clock),
      .reset         (reset),
      .ctl           (axis_ctl),
      .goal          (goal_y_ff),
      .load_value    (load_y_ff),
      .step_size     (step_size),
      .threshold     (threshold),
      .coils_next    (coils_y_next),
      .arrived_next  (arrived_y_next),
      .position_next (position_y_next)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_coils_x    = coils_x_ff;
   assign rsp_coils_y    = coils_y_ff;
   assign rsp_arrived_x  = arrived_x_ff;
   assign rsp_arrived_y  = arrived_y_ff;
   assign rsp_position_x = position_x_ff;
   assign rsp_position_y = position_y_ff;

   // back-pressure only ever comes from a held item in the input stage
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("req_stall raised with empty input stage");

   // a load never reports arrival
   assert property (@(posedge clock) disable iff (reset)
      (advance && op_ff == OP_LOAD) |=> (!rsp_arrived_x && !rsp_arrived_y))
      else $error("arrived flag set on a load item");

   // coils_x stays on the full-step sequence
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_coils_x == 4'b1010) || (rsp_coils_x == 4'b1001) ||
                     (rsp_coils_x == 4'b0101) || (rsp_coils_x == 4'b0110)))
      else $error("coils_x off the full-step sequence");

   // a result that moves on while the input stage is empty leaves nothing behind
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_valid_ff) |=> !rsp_valid)
      else $error("result repeated after being taken");

endmodule

// ===== tb/sv/two_axis_stepper_follower_tb.sv =====
// ----------------------------------------------------------------------------
// two_axis_stepper_follower_tb
// Self-checking bench for the two-axis full-step position follower.
// A scoreboard class carries its own copy of both axes, their phases and the
// step and deadband registers. Every accepted item is predicted on the spot
// and every accepted result is checked field by field in arrival order.
// The stimulus is a short directed run over the edge cases, then random
// items that are mostly goals close to the current position, under several
// register settings and with random stalls and gaps on both channels.
// ----------------------------------------------------------------------------
module two_axis_stepper_follower_tb
   import tasf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 11;
   localparam int IDLE_PCT     = 22;     // idle share of each side, percent
   localparam int HOLD_CYCLES  = 60;     // long receiver hold-off
   localparam int QUIET_LIMIT  = 1000;   // cycles without any handshake
   localparam int PHASE_ITEMS  = 140;    // random items per register setting
   localparam int NUM_PHASES   = 6;
   localparam int TAIL_CYCLES  = 8;      // two-stage pipe plus margin

   localparam field_type POS_MAX = 24'sh7fffff;
   localparam field_type POS_MIN = 24'sh800000;

   // one result item as seen on rsp_*
   typedef struct {
      coils_type coils_x;
      coils_type coils_y;
      logic      arrived_x;
      logic      arrived_y;
      field_type position_x;
      field_type position_y;
   } motion_type;

   // ------------------------------------------------------------------------
   // Scoreboard: axis state, register copy, and the results still owed
   // ------------------------------------------------------------------------
   class follower_scoreboard;
      coils_type  full_step_seq[4];
      pos_type    pos_x, pos_y;
      phase_type  phase_x, phase_y;
      cfg_type    step_size, tolerance;
      motion_type expected_motion[$];
      int         motion_errors, results_seen, ticks, loads, arrivals;

      function new();
         full_step_seq = '{4'b1010, 4'b1001, 4'b0101, 4'b0110};
         pos_x         = '0;
         pos_y         = '0;
         phase_x       = '0;
         phase_y       = '0;
         step_size     = STEP_SIZE_RESET;
         tolerance     = TOLERANCE_RESET;
      endfunction

      function void write_reg(logic idx, cfg_type val);
         if (idx == CSR_STEP_SIZE) begin
            step_size = val;
         end else begin
            tolerance = val;
         end
      endfunction

      function longint deadband();
         return longint'(tolerance) * longint'(step_size);
      endfunction

      // one tick of one axis; error is exact, position wraps at its width
      function void follow(inout pos_type pos, inout phase_type ph,
                           input field_type goal, output logic arrived);
         longint err;
         err     = longint'(pos) - longint'(goal);
         arrived = 1'b0;
         if (err < -deadband()) begin
            ph  = ph + 2'd1;
            pos = pos + pos_type'(step_size);
         end else if (err >= deadband()) begin
            ph  = ph - 2'd1;
            pos = pos - pos_type'(step_size);
         end else begin
            arrived = 1'b1;
         end
      endfunction

      function void note_item(logic op, field_type gx, field_type gy,
                              field_type lx, field_type ly);
         motion_type m;
         if (op == OP_LOAD) begin
            // positions replaced, phases kept
            pos_x       = lx;
            pos_y       = ly;
            m.arrived_x = 1'b0;
            m.arrived_y = 1'b0;
            loads++;
         end else begin
            follow(pos_x, phase_x, gx, m.arrived_x);
            follow(pos_y, phase_y, gy, m.arrived_y);
            arrivals += int'(m.arrived_x) + int'(m.arrived_y);
            ticks++;
         end
         m.coils_x    = full_step_seq[phase_x];
         m.coils_y    = full_step_seq[phase_y];
         m.position_x = pos_x;
         m.position_y = pos_y;
         expected_motion.push_back(m);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         if (motion_errors < 40)
            $display("mismatch on %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
         motion_errors++;
      endtask

      task check_result(motion_type r);
         motion_type e;
         if (expected_motion.size() == 0) begin
            report_mismatch("unexpected result, position_x", r.position_x, 0);
            return;
         end
         e = expected_motion.pop_front();
         if (r.coils_x !== e.coils_x)
            report_mismatch("coils_x", r.coils_x, e.coils_x);
         if (r.coils_y !== e.coils_y)
            report_mismatch("coils_y", r.coils_y, e.coils_y);
         if (r.arrived_x !== e.arrived_x)
            report_mismatch("arrived_x", r.arrived_x, e.arrived_x);
         if (r.arrived_y !== e.arrived_y)
            report_mismatch("arrived_y", r.arrived_y, e.arrived_y);
         if (r.position_x !== e.position_x)
            report_mismatch("position_x", r.position_x, e.position_x);
         if (r.position_y !== e.position_y)
            report_mismatch("position_y", r.position_y, e.position_y);
         results_seen++;
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Signals; every block input starts at a known value
   // ------------------------------------------------------------------------
   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      req_valid      = 1'b0;
   logic      req_stall;
   logic      req_op         = OP_TICK;
   field_type req_goal_x     = '0;
   field_type req_goal_y     = '0;
   field_type req_load_x     = '0;
   field_type req_load_y     = '0;
   logic      rsp_valid;
   logic      rsp_stall      = 1'b0;
   coils_type rsp_coils_x;
   coils_type rsp_coils_y;
   logic      rsp_arrived_x;
   logic      rsp_arrived_y;
   field_type rsp_position_x;
   field_type rsp_position_y;
   logic      csr_write      = 1'b0;
   logic      csr_index      = CSR_STEP_SIZE;
   cfg_type   csr_wdata      = '0;

   logic hold_request = 1'b0;   // asks the receiver for one long hold-off
   logic no_idle      = 1'b0;   // receiver never stalls while set
   int   quiet_cycles = 0;
   int   settings     = 0;

   follower_scoreboard sb;

   two_axis_stepper_follower u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Result side: stalls are driven at the rising edge, handshakes sampled at
   // the falling edge, where both sides are settled for the coming edge.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int hold_count;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            // hold off long enough for the pipe to fill and stall req_*
            rsp_stall    <= 1'b1;
            hold_request <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   always @(negedge clock) begin : monitor
      motion_type r;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            r.coils_x    = rsp_coils_x;
            r.coils_y    = rsp_coils_y;
            r.arrived_x  = rsp_arrived_x;
            r.arrived_y  = rsp_arrived_y;
            r.position_x = rsp_position_x;
            r.position_y = rsp_position_y;
            sb.check_result(r);
         end
      end
   end

   // a stuck handshake on either side ends the run
   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("** two_axis_stepper_follower: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Input side tasks; each is entered and left just after a rising edge
   // ------------------------------------------------------------------------
   task automatic send_item(logic op, field_type gx, field_type gy,
                            field_type lx, field_type ly);
      logic taken;
      req_valid  <= 1'b1;
      req_op     <= op;
      req_goal_x <= gx;
      req_goal_y <= gy;
      req_load_x <= lx;
      req_load_y <= ly;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      sb.note_item(op, gx, gy, lx, ly);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // always waits for a rising edge first, so valid never gets two updates
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_motion.size() != 0);
   endtask

   // registers change only with the pipe empty
   task automatic set_config(cfg_type step, cfg_type tol);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_STEP_SIZE;
      csr_wdata <= step;
      @(posedge clock);
      sb.write_reg(CSR_STEP_SIZE, step);
      csr_index <= CSR_TOLERANCE;
      csr_wdata <= tol;
      @(posedge clock);
      sb.write_reg(CSR_TOLERANCE, tol);
      csr_write <= 1'b0;
      @(posedge clock);
      settings++;
   endtask

   // near either end of the position range, or zero
   function automatic field_type pick_edge();
      case ($urandom_range(2))
         0:       return POS_MAX - field_type'($urandom_range(3));
         1:       return POS_MIN + field_type'($urandom_range(3));
         default: return '0;
      endcase
   endfunction

   // goal around the current position, often right on the deadband edge
   function automatic field_type near_goal(pos_type p);
      longint thr, span, off;
      thr  = sb.deadband();
      span = thr + 2 * longint'(sb.step_size) + 2;
      case ($urandom_range(3))
         0:       off = thr;
         1:       off = -thr;
         2:       off = ($urandom_range(1) ? thr : -thr) +
                        longint'($urandom_range(2)) - 1;
         default: off = longint'($urandom_range(2 * span)) - span;
      endcase
      return field_type'(longint'(p) + off);
   endfunction

   task automatic send_random_item();
      int        kind;
      field_type gx, gy, lx, ly;
      kind = $urandom_range(99);
      gx   = field_type'($urandom);
      gy   = field_type'($urandom);
      lx   = field_type'($urandom);
      ly   = field_type'($urandom);
      if (kind < 10) begin
         if ($urandom_range(3) == 0) begin
            lx = pick_edge();
            ly = pick_edge();
         end
         send_item(OP_LOAD, gx, gy, lx, ly);
      end else if (kind < 20) begin
         // far goals anywhere in range
         send_item(OP_TICK, gx, gy, lx, ly);
      end else if (kind < 25) begin
         send_item(OP_TICK, pick_edge(), pick_edge(), lx, ly);
      end else begin
         send_item(OP_TICK, near_goal(sb.pos_x), near_goal(sb.pos_y), lx, ly);
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int      ph;
      int      i;
      cfg_type step, tol;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: step 12, deadband 48
      send_item(OP_TICK, 0, 0, 24'h555555, 24'haaaaaa);    // on target
      send_item(OP_TICK, 48, -48, 24'haaaaaa, 24'h555555); // exactly on edges
      send_item(OP_TICK, 49, -47, 0, 0);                   // just past / inside
      send_item(OP_LOAD, 24'haaaaaa, 24'h555555, POS_MAX, POS_MIN);
      send_item(OP_TICK, POS_MIN, POS_MAX, 0, 0);          // widest error
      send_item(OP_LOAD, 0, 0, 0, 0);
      repeat (4) send_item(OP_TICK, 1000, -1000, 0, 0);    // full coil cycle

      // zero step: phase walks, position stays
      set_config(8'd0, 8'd3);
      send_item(OP_TICK, 100, -100, 0, 0);
      send_item(OP_TICK, 0, 0, 0, 0);
      send_item(OP_TICK, -5, 5, 0, 0);

      // zero deadband: never arrived; positions wrap at both ends
      set_config(8'd12, 8'd0);
      send_item(OP_LOAD, 0, 0, POS_MAX - 7, POS_MIN + 8);
      send_item(OP_TICK, POS_MAX, POS_MIN, 0, 0);
      send_item(OP_TICK, 0, 0, 0, 0);

      // widest deadband
      set_config(8'd255, 8'd255);
      send_item(OP_LOAD, 0, 0, 0, 0);
      send_item(OP_TICK, 65025, -65025, 0, 0);
      send_item(OP_TICK, 65026, -65024, 0, 0);
      send_item(OP_TICK, POS_MAX, POS_MIN, 0, 0);

      // random phases, one register setting each
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin step = 8'd1;   tol = 8'd0;   end
            1: begin step = 8'd255; tol = 8'd255; end
            3: begin step = 8'd0;   tol = cfg_type'($urandom); end
            default: begin
               step = cfg_type'($urandom_range(1, 255));
               tol  = cfg_type'($urandom_range(0, 12));
            end
         endcase
         set_config(step, tol);
         no_idle <= (ph == 2);      // back-to-back stretch on both sides
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 3 && i == 20)
               hold_request <= 1'b1;
            if (ph == 4 && i == PHASE_ITEMS / 2)
               wait_drained();
            // idle gaps are drawn cycle by cycle, each with the idle share as odds
            if (ph != 2 && ph != 3)
               while ($urandom_range(99) < IDLE_PCT)
                  pause_sender(1);
            send_random_item();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d ticks and %0d loads under %0d register settings,",
               sb.ticks, sb.loads, settings + 1);
      $display("incl. zero step, zero and widest deadband, wrap; %0d arrivals, %0d checked.",
               sb.arrivals, sb.results_seen);
      if (sb.motion_errors == 0) begin
         $display("** two_axis_stepper_follower: PASSED **");
      end else begin
         $display("** two_axis_stepper_follower: FAILED **");
      end
      $finish;
   end

endmodule
